// ----- rtl/ccdxt_pkg.sv -----
`default_nettype none

package ccdxt_pkg;

	localparam int LANES         = 4;
	localparam int PIXEL_BITS    = 20;
	localparam int COEFF_BITS    = 16;
	localparam int COEFF_FRAC    = 20;
	localparam int SECONDARY_LAG = 2;

	// eight 64-bit coefficient registers: four primary rows, then four lag rows
	localparam int REG_BITS  = 64;
	localparam int NUM_REGS  = 2 * LANES;
	localparam int IDX_BITS  = $clog2(NUM_REGS);
	localparam int ADDR_LSB  = 3;
	localparam int ADDR_BITS = IDX_BITS + ADDR_LSB;

	localparam int POS_BITS  = $clog2(SECONDARY_LAG + 1);
	localparam int PROD_BITS = PIXEL_BITS + COEFF_BITS;
	// eight products plus the rounding bias, with a spare bit
	localparam int SUM_BITS  = PROD_BITS + 4;

	typedef logic signed [PIXEL_BITS-1:0] pixel_t;
	typedef logic signed [COEFF_BITS-1:0] coeff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [SUM_BITS-1:0]   sum_t;
	typedef logic [POS_BITS-1:0]          pos_t;

	localparam pos_t LAG_POS    = pos_t'(SECONDARY_LAG);
	localparam sum_t ROUND_BIAS = sum_t'(1) <<< (COEFF_FRAC - 1);
	localparam sum_t PIX_MAX    = sum_t'({1'b0, {(PIXEL_BITS-1){1'b1}}});
	localparam sum_t PIX_MIN    = -PIX_MAX - sum_t'(1);

	typedef struct packed {
		logic load_s2;
		logic load_s3;
	} ccdxt_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/ccdxt_lane.sv -----
`default_nettype none

module ccdxt_lane (
	input  wire logic                              clk,
	input  wire ccdxt_pkg::ccdxt_ctrl_t            ctrl,
	input  wire ccdxt_pkg::pixel_t                 px_s1 [ccdxt_pkg::LANES],
	input  wire ccdxt_pkg::pixel_t                 lag_s1 [ccdxt_pkg::LANES],
	input  wire ccdxt_pkg::pixel_t                 own_s1,
	input  wire logic                              apply_s1,
	input  wire logic [ccdxt_pkg::REG_BITS-1:0]    prim_row,
	input  wire logic [ccdxt_pkg::REG_BITS-1:0]    sec_row,
	output ccdxt_pkg::pixel_t                      corrected,
	output logic                                   clip
);

	ccdxt_pkg::prod_t  prim_prod_d [ccdxt_pkg::LANES];
	ccdxt_pkg::prod_t  sec_prod_d [ccdxt_pkg::LANES];
	ccdxt_pkg::prod_t  prim_prod_s2 [ccdxt_pkg::LANES];
	ccdxt_pkg::prod_t  sec_prod_s2 [ccdxt_pkg::LANES];
	ccdxt_pkg::pixel_t own_s2;
	logic              apply_s2;

	ccdxt_pkg::sum_t   acc;
	ccdxt_pkg::sum_t   offset;
	ccdxt_pkg::sum_t   diff;
	ccdxt_pkg::pixel_t res_d;
	logic              clip_d;
	ccdxt_pkg::pixel_t corrected_s3;
	logic              clip_s3;

	// one product per source amplifier, current and lagged
	always_comb begin
		for (int k = 0; k < ccdxt_pkg::LANES; k++) begin
			prim_prod_d[k] = ccdxt_pkg::prod_t'(px_s1[k]) *
				ccdxt_pkg::prod_t'(ccdxt_pkg::coeff_t'(
					prim_row[k*ccdxt_pkg::COEFF_BITS +: ccdxt_pkg::COEFF_BITS]));
			sec_prod_d[k] = ccdxt_pkg::prod_t'(lag_s1[k]) *
				ccdxt_pkg::prod_t'(ccdxt_pkg::coeff_t'(
					sec_row[k*ccdxt_pkg::COEFF_BITS +: ccdxt_pkg::COEFF_BITS]));
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			prim_prod_s2 <= prim_prod_d;
			sec_prod_s2  <= sec_prod_d;
			own_s2       <= own_s1;
			apply_s2     <= apply_s1;
		end
	end

	always_comb begin
		acc = ccdxt_pkg::ROUND_BIAS;
		for (int k = 0; k < ccdxt_pkg::LANES; k++) begin
			acc = acc + ccdxt_pkg::sum_t'(prim_prod_s2[k]) + ccdxt_pkg::sum_t'(sec_prod_s2[k]);
		end
		// floor shift rounds to nearest with ties upward thanks to the bias
		offset = acc >>> ccdxt_pkg::COEFF_FRAC;
		diff   = ccdxt_pkg::sum_t'(own_s2) - offset;
		res_d  = own_s2;
		clip_d = 1'b0;
		if (apply_s2) begin
			priority if (diff > ccdxt_pkg::PIX_MAX) begin
				res_d  = ccdxt_pkg::pixel_t'(ccdxt_pkg::PIX_MAX[ccdxt_pkg::PIXEL_BITS-1:0]);
				clip_d = 1'b1;
			end else if (diff < ccdxt_pkg::PIX_MIN) begin
				res_d  = ccdxt_pkg::pixel_t'(ccdxt_pkg::PIX_MIN[ccdxt_pkg::PIXEL_BITS-1:0]);
				clip_d = 1'b1;
			end else begin
				res_d  = ccdxt_pkg::pixel_t'(diff[ccdxt_pkg::PIXEL_BITS-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s3) begin
			corrected_s3 <= res_d;
			clip_s3      <= clip_d;
		end
	end

	assign corrected = corrected_s3;
	assign clip      = clip_s3;

endmodule

`default_nettype wire

// ----- rtl/ccd_crosstalk_subtract_core.sv -----
// A result moves through the s1, s2 and s3 registers after its input beat is accepted.
// Throughput: one beat per cycle unless out_stall holds; per lane, eight 20x16
// multipliers feed a registered eight-term adder; three valid stages close bubbles.
// Reset (arst_n low, asynchronous): coefficient registers, row position and all
// valid bits clear; pixel history and data registers are not reset.
`default_nettype none

module ccd_crosstalk_subtract_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [ccdxt_pkg::ADDR_BITS-1:0]    paddr,
	input  wire logic [ccdxt_pkg::REG_BITS-1:0]     pwdata,
	output logic [ccdxt_pkg::REG_BITS-1:0]          prdata,
	output logic                                    pready,
	// input channel
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire ccdxt_pkg::pixel_t                  pixel_a,
	input  wire ccdxt_pkg::pixel_t                  pixel_b,
	input  wire ccdxt_pkg::pixel_t                  pixel_c,
	input  wire ccdxt_pkg::pixel_t                  pixel_d,
	input  wire logic                               first_of_row,
	// output channel
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output ccdxt_pkg::pixel_t                       corrected_a,
	output ccdxt_pkg::pixel_t                       corrected_b,
	output ccdxt_pkg::pixel_t                       corrected_c,
	output ccdxt_pkg::pixel_t                       corrected_d,
	output logic                                    clipped
);

	logic [ccdxt_pkg::REG_BITS-1:0] cfg_q [ccdxt_pkg::NUM_REGS];
	logic [ccdxt_pkg::IDX_BITS-1:0] reg_idx;

	ccdxt_pkg::pixel_t px_in [ccdxt_pkg::LANES];
	ccdxt_pkg::pixel_t hist_q [ccdxt_pkg::SECONDARY_LAG][ccdxt_pkg::LANES];
	ccdxt_pkg::pos_t   pos_q;
	ccdxt_pkg::pos_t   pos;
	logic              accept;

	ccdxt_pkg::pixel_t px_s1 [ccdxt_pkg::LANES];
	ccdxt_pkg::pixel_t lag_s1 [ccdxt_pkg::LANES];
	logic              apply_s1;

	logic              v1_q, v2_q, v3_q;
	logic              ready1, ready2, ready3;
	ccdxt_pkg::ccdxt_ctrl_t ctrl;

	ccdxt_pkg::pixel_t lane_out [ccdxt_pkg::LANES];
	logic [ccdxt_pkg::LANES-1:0] lane_clip;

	// configuration registers
	assign reg_idx = paddr[ccdxt_pkg::ADDR_BITS-1:ccdxt_pkg::ADDR_LSB];
	assign pready  = 1'b1;
	assign prdata  = cfg_q[reg_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ccdxt_pkg::NUM_REGS; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (psel && penable && pwrite && pready) begin
			cfg_q[reg_idx] <= pwdata;
		end
	end

	// pipeline handshake: a stage loads when it is empty or its beat moves on
	assign ready3       = !v3_q || !out_stall;
	assign ready2       = !v2_q || ready3;
	assign ready1       = !v1_q || ready2;
	assign in_stall     = !ready1;
	assign accept       = in_valid && ready1;
	assign ctrl.load_s2 = v1_q && ready2;
	assign ctrl.load_s3 = v2_q && ready3;
	assign out_valid    = v3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (ready1) v1_q <= in_valid;
			if (ready2) v2_q <= v1_q;
			if (ready3) v3_q <= v2_q;
		end
	end

	assign px_in[0] = pixel_a;
	assign px_in[1] = pixel_b;
	assign px_in[2] = pixel_c;
	assign px_in[3] = pixel_d;

	// a row mark restarts the count on this very beat
	assign pos = first_of_row ? '0 : pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= (pos == ccdxt_pkg::LAG_POS) ? ccdxt_pkg::LAG_POS : pos + ccdxt_pkg::pos_t'(1);
		end
	end

	// raw pixel history and the stage-one register, both advanced per accepted beat
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1    <= px_in;
			lag_s1   <= hist_q[ccdxt_pkg::SECONDARY_LAG-1];
			apply_s1 <= (pos == ccdxt_pkg::LAG_POS);
			hist_q[0] <= px_in;
			for (int i = 1; i < ccdxt_pkg::SECONDARY_LAG; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	for (genvar lane = 0; lane < ccdxt_pkg::LANES; lane++) begin : g_lane
		ccdxt_lane u_lane (
			.clk       (clk),
			.ctrl      (ctrl),
			.px_s1     (px_s1),
			.lag_s1    (lag_s1),
			.own_s1    (px_s1[lane]),
			.apply_s1  (apply_s1),
			.prim_row  (cfg_q[lane]),
			.sec_row   (cfg_q[ccdxt_pkg::LANES + lane]),
			.corrected (lane_out[lane]),
			.clip      (lane_clip[lane])
		);
	end

	assign corrected_a = lane_out[0];
	assign corrected_b = lane_out[1];
	assign corrected_c = lane_out[2];
	assign corrected_d = lane_out[3];
	assign clipped     = |lane_clip;

	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v1_q && v2_q && v3_q))
		else $error("input stalled with a free pipeline stage");

	a_drain_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= ccdxt_pkg::LAG_POS)
		else $error("row position beyond lag");

	a_row_start_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && first_of_row) |=> !apply_s1)
		else $error("correction applied to first beat of a row");

	a_load_needs_source: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_s3 |=> v3_q)
		else $error("result stage loaded but not valid");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int PRIMARY_BASE   = 0;
	localparam int SECONDARY_BASE = ccdxt_pkg::LANES;

	localparam logic [ccdxt_pkg::COEFF_BITS-1:0] COEFF_NEG_FULL =
		{1'b1, {(ccdxt_pkg::COEFF_BITS-1){1'b0}}};
	localparam logic [ccdxt_pkg::COEFF_BITS-1:0] COEFF_POS_FULL =
		{1'b0, {(ccdxt_pkg::COEFF_BITS-1){1'b1}}};
	localparam logic [ccdxt_pkg::REG_BITS-1:0]   ROW_NEG_FULL   =
		{ccdxt_pkg::LANES{COEFF_NEG_FULL}};
	localparam logic [ccdxt_pkg::REG_BITS-1:0]   ROW_POS_FULL   =
		{ccdxt_pkg::LANES{COEFF_POS_FULL}};

	localparam ccdxt_pkg::pixel_t PX_HI   =
		ccdxt_pkg::pixel_t'((64'sd1 <<< (ccdxt_pkg::PIXEL_BITS-1)) - 1);
	localparam ccdxt_pkg::pixel_t PX_LO   =
		ccdxt_pkg::pixel_t'(-(64'sd1 <<< (ccdxt_pkg::PIXEL_BITS-1)));
	localparam ccdxt_pkg::pixel_t PX_HALF =
		ccdxt_pkg::pixel_t'(64'sd1 <<< (ccdxt_pkg::PIXEL_BITS-2));

	typedef struct packed {
		ccdxt_pkg::pixel_t [ccdxt_pkg::LANES-1:0] pix;
		logic                                     first;
	} raw_beat_t;

	typedef struct packed {
		ccdxt_pkg::pixel_t [ccdxt_pkg::LANES-1:0] pix;
		logic                                     clip;
	} corrected_beat_t;

	logic                            clk;
	logic                            arst_n       = 1'b0;
	logic                            psel         = 1'b0;
	logic                            penable      = 1'b0;
	logic                            pwrite       = 1'b0;
	logic [ccdxt_pkg::ADDR_BITS-1:0] paddr        = '0;
	logic [ccdxt_pkg::REG_BITS-1:0]  pwdata       = '0;
	logic [ccdxt_pkg::REG_BITS-1:0]  prdata;
	logic                            pready;
	logic                            in_valid     = 1'b0;
	logic                            in_stall;
	ccdxt_pkg::pixel_t               pixel_a      = '0;
	ccdxt_pkg::pixel_t               pixel_b      = '0;
	ccdxt_pkg::pixel_t               pixel_c      = '0;
	ccdxt_pkg::pixel_t               pixel_d      = '0;
	logic                            first_of_row = 1'b0;
	logic                            out_valid;
	logic                            out_stall    = 1'b0;
	ccdxt_pkg::pixel_t               corrected_a;
	ccdxt_pkg::pixel_t               corrected_b;
	ccdxt_pkg::pixel_t               corrected_c;
	ccdxt_pkg::pixel_t               corrected_d;
	logic                            clipped;

	ccd_crosstalk_subtract_core dut (.*);

	// shadow of the coefficient registers and the per-lane raw pixel history
	logic [ccdxt_pkg::REG_BITS-1:0] coeff_regs [ccdxt_pkg::NUM_REGS];
	longint              hist_lag1 [ccdxt_pkg::LANES];
	longint              hist_lag2 [ccdxt_pkg::LANES];
	int                  row_position;
	corrected_beat_t     pending_corrections [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_off_left = 0;
	int error_count   = 0;
	int beats_sent    = 0;
	int results_seen  = 0;
	int clipped_seen  = 0;
	int reg_writes    = 0;
	int cycle_count   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_corrections.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic corrected_beat_t predict_correction(input raw_beat_t b);
		corrected_beat_t r;
		longint          px [ccdxt_pkg::LANES];
		longint          sum;
		longint          off;
		longint          res;
		int              pos;
		pos = b.first ? 0 : row_position;
		r   = '0;
		for (int l = 0; l < ccdxt_pkg::LANES; l++)
			px[l] = longint'($signed(b.pix[l]));
		for (int l = 0; l < ccdxt_pkg::LANES; l++) begin
			res = px[l];
			if (pos >= ccdxt_pkg::SECONDARY_LAG) begin
				sum = 0;
				for (int s = 0; s < ccdxt_pkg::LANES; s++) begin
					sum += px[s] * longint'($signed(coeff_regs[PRIMARY_BASE + l]
						[s*ccdxt_pkg::COEFF_BITS +: ccdxt_pkg::COEFF_BITS]));
					sum += hist_lag2[s] * longint'($signed(coeff_regs[SECONDARY_BASE + l]
						[s*ccdxt_pkg::COEFF_BITS +: ccdxt_pkg::COEFF_BITS]));
				end
				// arithmetic shift floors, so the bias gives round half up
				off = (sum + (64'sd1 <<< (ccdxt_pkg::COEFF_FRAC-1))) >>> ccdxt_pkg::COEFF_FRAC;
				res = px[l] - off;
				if (res > longint'(PX_HI)) begin
					res    = longint'(PX_HI);
					r.clip = 1'b1;
				end
				if (res < longint'(PX_LO)) begin
					res    = longint'(PX_LO);
					r.clip = 1'b1;
				end
			end
			r.pix[l] = res[ccdxt_pkg::PIXEL_BITS-1:0];
		end
		for (int l = 0; l < ccdxt_pkg::LANES; l++) begin
			hist_lag2[l] = hist_lag1[l];
			hist_lag1[l] = px[l];
		end
		row_position = (pos + 1 >= ccdxt_pkg::SECONDARY_LAG) ? ccdxt_pkg::SECONDARY_LAG : pos + 1;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint want_v, input longint got_v);
		if (error_count < 10)
			$display("mismatch at result %0d, %s: expected %0d, got %0d", results_seen, what,
				want_v, got_v);
		error_count++;
	endtask

	// output side: check accepted beats, then pick the next stall level
	always @(posedge clk) begin
		corrected_beat_t seen;
		corrected_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen.pix[0] = corrected_a;
			seen.pix[1] = corrected_b;
			seen.pix[2] = corrected_c;
			seen.pix[3] = corrected_d;
			seen.clip   = clipped;
			if (clipped)
				clipped_seen++;
			if (pending_corrections.size() == 0) begin
				if (error_count < 10)
					$display("result beat %0d arrived with nothing expected", results_seen);
				error_count++;
			end else begin
				want = pending_corrections.pop_front();
				for (int l = 0; l < ccdxt_pkg::LANES; l++)
					if (seen.pix[l] !== want.pix[l])
						report_mismatch($sformatf("lane %0d", l), longint'($signed(want.pix[l])),
							longint'($signed(seen.pix[l])));
				if (seen.clip !== want.clip)
					report_mismatch("clipped", longint'(want.clip), longint'(seen.clip));
			end
			results_seen++;
		end
		if (hold_off_left > 0) begin
			out_stall <= 1'b1;
			hold_off_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic send_beat(input raw_beat_t b);
		in_valid     <= 1'b1;
		pixel_a      <= b.pix[0];
		pixel_b      <= b.pix[1];
		pixel_c      <= b.pix[2];
		pixel_d      <= b.pix[3];
		first_of_row <= b.first;
		do @(posedge clk); while (in_stall);
		pending_corrections.push_back(predict_correction(b));
		beats_sent++;
	endtask

	task automatic idle_input(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic maybe_idle();
		while ($urandom_range(99) < send_idle_pct)
			idle_input(1);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_corrections.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(input int idx, input logic [ccdxt_pkg::REG_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ccdxt_pkg::ADDR_BITS'(idx) << ccdxt_pkg::ADDR_LSB;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		coeff_regs[idx] = value;
		reg_writes++;
		// psel is low again before the next transfer
		@(posedge clk);
	endtask

	task automatic write_all_coeffs(input logic [ccdxt_pkg::REG_BITS-1:0] value);
		for (int i = 0; i < ccdxt_pkg::NUM_REGS; i++)
			apb_write(i, value);
	endtask

	// each coefficient slice is random, zero or one of the two full-scale values
	task automatic randomize_coeffs();
		logic [ccdxt_pkg::REG_BITS-1:0] value;
		for (int i = 0; i < ccdxt_pkg::NUM_REGS; i++) begin
			for (int s = 0; s < ccdxt_pkg::LANES; s++)
				case ($urandom_range(7))
					0:       value[s*ccdxt_pkg::COEFF_BITS +: ccdxt_pkg::COEFF_BITS] = COEFF_NEG_FULL;
					1:       value[s*ccdxt_pkg::COEFF_BITS +: ccdxt_pkg::COEFF_BITS] = COEFF_POS_FULL;
					2:       value[s*ccdxt_pkg::COEFF_BITS +: ccdxt_pkg::COEFF_BITS] = '0;
					default: value[s*ccdxt_pkg::COEFF_BITS +: ccdxt_pkg::COEFF_BITS] =
						ccdxt_pkg::COEFF_BITS'($urandom());
				endcase
			apb_write(i, value);
		end
	endtask

	function automatic ccdxt_pkg::pixel_t px_of(input int v);
		return ccdxt_pkg::pixel_t'(v);
	endfunction

	function automatic raw_beat_t beat_of(input logic first, input ccdxt_pkg::pixel_t a,
			input ccdxt_pkg::pixel_t b, input ccdxt_pkg::pixel_t c, input ccdxt_pkg::pixel_t d);
		raw_beat_t r;
		r.first  = first;
		r.pix[0] = a;
		r.pix[1] = b;
		r.pix[2] = c;
		r.pix[3] = d;
		return r;
	endfunction

	function automatic ccdxt_pkg::pixel_t rand_pixel();
		case ($urandom_range(7))
			0:       return PX_HI;
			1:       return PX_LO;
			2:       return ccdxt_pkg::pixel_t'(int'($urandom_range(255)) - 128);
			default: return ccdxt_pkg::pixel_t'($urandom());
		endcase
	endfunction

	function automatic raw_beat_t random_beat(input logic first);
		return beat_of(first, rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
	endfunction

	// reset coefficients are zero, and no row mark is given: pixels pass through
	task automatic test_reset_defaults();
		send_beat(beat_of(1'b0, PX_HI, PX_LO, '0, px_of(-1)));
		send_beat(beat_of(1'b0, PX_LO, PX_HI, px_of(-1), '0));
		send_beat(beat_of(1'b0, PX_HI, PX_HI, PX_LO, PX_LO));
		send_beat(beat_of(1'b0, PX_LO, PX_LO, PX_HI, PX_HI));
		wait_drain();
	endtask

	task automatic test_saturation_extremes();
		write_all_coeffs(ROW_NEG_FULL);
		send_beat(beat_of(1'b1, PX_HI, PX_HI, PX_HI, PX_HI));
		send_beat(beat_of(1'b0, PX_HI, PX_HI, PX_HI, PX_HI));
		send_beat(beat_of(1'b0, PX_HI, PX_HI, PX_HI, PX_HI));
		send_beat(beat_of(1'b0, PX_LO, PX_LO, PX_LO, PX_LO));
		send_beat(beat_of(1'b0, PX_LO, PX_LO, PX_LO, PX_LO));
		send_beat(beat_of(1'b0, PX_LO, PX_LO, PX_LO, PX_LO));
		send_beat(beat_of(1'b0, '0, '0, '0, '0));
		send_beat(beat_of(1'b0, px_of(-1), px_of(-1), px_of(-1), px_of(-1)));
		wait_drain();
		write_all_coeffs(ROW_POS_FULL);
		send_beat(beat_of(1'b1, PX_LO, PX_LO, PX_LO, PX_LO));
		send_beat(beat_of(1'b0, PX_LO, PX_LO, PX_LO, PX_LO));
		send_beat(beat_of(1'b0, PX_HI, PX_LO, PX_LO, PX_LO));
		send_beat(beat_of(1'b0, PX_LO, PX_HI, PX_HI, PX_HI));
		send_beat(beat_of(1'b0, PX_HI, PX_HI, PX_HI, PX_HI));
		send_beat(beat_of(1'b0, PX_LO, PX_LO, PX_LO, PX_HI));
		wait_drain();
	endtask

	// exact half-way offsets of both signs, then row marks on back-to-back beats
	task automatic test_rounding_and_row_marks();
		write_all_coeffs('0);
		apb_write(PRIMARY_BASE + 0, ccdxt_pkg::REG_BITS'(2));
		apb_write(SECONDARY_BASE + 1, ccdxt_pkg::REG_BITS'(1));
		send_beat(beat_of(1'b1, PX_LO, px_of(5), px_of(-5), '0));
		send_beat(beat_of(1'b0, '0, px_of(7), px_of(7), px_of(7)));
		send_beat(beat_of(1'b0, PX_HALF, px_of(11), px_of(-11), PX_HI));
		send_beat(beat_of(1'b1, -PX_HALF, px_of(1), px_of(2), px_of(3)));
		send_beat(beat_of(1'b1, PX_HALF, px_of(-1), px_of(-2), px_of(-3)));
		send_beat(beat_of(1'b0, PX_LO, PX_HI, '0, '0));
		send_beat(beat_of(1'b0, -PX_HALF, PX_HI, PX_LO, px_of(-1)));
		wait_drain();
	endtask

	// hold the output long enough to fill the block and stall its input
	task automatic test_backpressure();
		randomize_coeffs();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_left = 120;
		for (int k = 0; k < 40; k++)
			send_beat(random_beat(k % 10 == 0));
		wait_drain();
	endtask

	task automatic run_random_phase(input int n, input int send_pct, input int recv_pct);
		int sent;
		int row_len;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		randomize_coeffs();
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(9) == 0) begin
				// lone beat with a random row mark
				maybe_idle();
				send_beat(random_beat(1'($urandom_range(1))));
				sent++;
			end else begin
				row_len = $urandom_range(3, 24);
				for (int k = 0; k < row_len && sent < n; k++) begin
					maybe_idle();
					send_beat(random_beat(k == 0));
					sent++;
				end
			end
		end
		wait_drain();
	endtask

	initial begin
		for (int i = 0; i < ccdxt_pkg::NUM_REGS; i++)
			coeff_regs[i] = '0;
		for (int l = 0; l < ccdxt_pkg::LANES; l++) begin
			hist_lag1[l] = 0;
			hist_lag2[l] = 0;
		end
		row_position = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_saturation_extremes();
		test_rounding_and_row_marks();
		test_backpressure();
		run_random_phase(530, 14, 45);
		run_random_phase(530, 45, 14);
		run_random_phase(530, 0, 0);

		wait_drain();
		repeat (8) @(posedge clk);
		error_count += pending_corrections.size();

		$display("%0d beats in, %0d corrected beats checked (%0d saturated), %0d errors",
			beats_sent, results_seen, clipped_seen, error_count);
		$display("covered row marks, full-scale values, half-way rounding, hold-off, idle mixes");
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
